[hw/rtl/afts_pkg.sv]
// Shared types and constants for the animation frame timeline select unit.
package afts_pkg;

  // Default depth of the frame duration store.
  localparam int unsigned MAX_FRAMES_DEF = 256;

  // Playback time width and the width of a sum over one whole sequence
  // (at most 510 entries of 16 bits each).
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SUM_W  = 26;

  // Item kinds.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [1:0] CFG_TAG_FIRST   = 2'd1;
  localparam logic [1:0] CFG_TAG_LAST    = 2'd2;
  localparam logic [1:0] CFG_TAG_DIR     = 2'd3;

  // Tag playback directions.
  typedef enum logic [1:0] {
    DIR_FWD = 2'd0,
    DIR_REV = 2'd1,
    DIR_PP  = 2'd2,
    DIR_RPP = 2'd3
  } dir_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FRAMES = 2'd1,
    ST_BAD_TAG   = 2'd2
  } status_t;

endpackage

[hw/rtl/afts_div.sv]
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit per cycle.
module afts_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [afts_pkg::TIME_W-1:0]  dividend,
  input  logic [afts_pkg::SUM_W-1:0]   divisor,
  output logic                         done,
  output logic [afts_pkg::SUM_W-1:0]   remainder
);

  localparam int unsigned CNT_W = $clog2(afts_pkg::TIME_W + 1);

  logic [afts_pkg::TIME_W-1:0] quo;
  logic [afts_pkg::SUM_W-1:0]  rem;
  logic [CNT_W-1:0]            cnt;
  logic                        running;
  logic [afts_pkg::SUM_W:0]    trial;

  // Shift the next dividend bit into the partial remainder.
  assign trial     = {rem, quo[afts_pkg::TIME_W-1]};
  assign remainder = rem;

  // One restoring step per cycle; the count runs down over the dividend bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        quo     <= dividend;
        rem     <= '0;
        cnt     <= CNT_W'(afts_pkg::TIME_W);
        running <= 1'b1;
      end else if (running) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= afts_pkg::SUM_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[afts_pkg::SUM_W-1:0];
        end
        quo <= quo << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/animation_frame_timeline_select_unit.sv]
// Top level of the animation frame timeline select unit.
//
// Items enter on start while busy is low. A load item (mode 0) writes one
// frame duration and returns its slot with status ok on the cycle after
// acceptance; busy stays low, so loads can follow each other every cycle.
// A query item (mode 1) picks the frame shown at time_ms, either over the
// whole animation or over the configured tag sequence, of up to 510
// entries. Its result comes from a walk that sums the sequence, the
// remainder unit when that sum is nonzero, and a walk that scans for
// the frame, each walk reading the duration memory one entry a cycle.
// Busy is high for the whole query. A query rejected for no frames or a
// bad tag answers on the next cycle.
// Each result beat sits on frame_index and status for exactly one cycle,
// marked by done; the receiver cannot stall it.
// Configuration writes go over cfg_valid/cfg_ready (always ready). The user
// must make them only while the block is idle; the block does not enforce it.
// Reset clears the configuration registers and the sequencer. The duration
// memory is not cleared; load every frame before querying it.
module animation_frame_timeline_select_unit #(
  parameter int unsigned MAX_FRAMES = afts_pkg::MAX_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Item channel
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [7:0]  frame_slot,
  input  logic [15:0] duration_ms,
  input  logic [31:0] time_ms,
  input  logic        use_tag,
  // Result channel
  output logic        done,
  output logic [7:0]  frame_index,
  output logic [1:0]  status,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int unsigned AW  = $clog2(MAX_FRAMES);
  localparam int unsigned CAP = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam int unsigned TW  = afts_pkg::TIME_W;
  localparam int unsigned SW  = afts_pkg::SUM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t state;

  logic [8:0]  frame_count;
  logic [7:0]  tag_first;
  logic [7:0]  tag_last;
  logic [1:0]  tag_direction;

  logic [15:0] mem [MAX_FRAMES];
  logic [15:0] rdata;
  logic [AW-1:0] rd_addr;

  logic        q_tag;
  logic [8:0]  len;
  logic [8:0]  k;
  logic        rd_pend;
  logic [7:0]  f_pend;
  logic [TW-1:0] t;
  logic [SW-1:0] total;
  logic [SW-1:0] acc;
  logic [SW-1:0] acc_sum;
  logic        div_go;
  logic        div_done;
  logic [SW-1:0] div_rem;

  logic [8:0]  count;
  logic [8:0]  tag_n;
  logic [8:0]  tag_len;
  logic        tag_bad;
  logic        accept;
  logic        issue;
  logic [7:0]  cur_entry;
  logic [7:0]  last_entry;
  logic        walk_end;

  // Frame at position kk of the active sequence.
  function automatic logic [7:0] seq_entry(input logic [8:0] kk);
    logic [9:0] v;
    v = 10'(kk);
    if (q_tag) begin
      case (afts_pkg::dir_t'(tag_direction))
        afts_pkg::DIR_FWD: v = 10'(tag_first) + 10'(kk);
        afts_pkg::DIR_REV: v = 10'(tag_last) - 10'(kk);
        afts_pkg::DIR_PP: begin
          if (kk < tag_n) v = 10'(tag_first) + 10'(kk);
          else v = 10'(tag_first) + (10'(tag_n) << 1) - 10'd2 - 10'(kk);
        end
        default: begin
          if (kk < tag_n) v = 10'(tag_last) - 10'(kk);
          else v = 10'(tag_first) + 10'(kk) - 10'(tag_n) + 10'd1;
        end
      endcase
    end
    return v[7:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  // Effective frame count and tag sequence shape.
  assign count   = (frame_count > 9'(CAP)) ? 9'(CAP) : frame_count;
  assign tag_n   = {1'b0, tag_last} - {1'b0, tag_first} + 9'd1;
  assign tag_len = (tag_direction[1] && tag_n > 9'd2) ? ((tag_n << 1) - 9'd2) : tag_n;
  assign tag_bad = ({1'b0, tag_first} >= count) || ({1'b0, tag_last} >= count) ||
                   (tag_first > tag_last);

  // Walk control shared by the sum and scan passes.
  assign issue      = (k < len);
  assign cur_entry  = seq_entry(k);
  assign last_entry = seq_entry(len - 9'd1);
  assign rd_addr    = AW'(cur_entry);
  assign walk_end   = !issue && !rd_pend;
  assign acc_sum    = acc + SW'(rdata);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      tag_first     <= '0;
      tag_last      <= '0;
      tag_direction <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        afts_pkg::CFG_FRAME_COUNT: frame_count   <= cfg_data;
        afts_pkg::CFG_TAG_FIRST:   tag_first     <= cfg_data[7:0];
        afts_pkg::CFG_TAG_LAST:    tag_last      <= cfg_data[7:0];
        afts_pkg::CFG_TAG_DIR:     tag_direction <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Duration memory: written by load items, read one entry a cycle by the walk.
  always_ff @(posedge clk) begin
    if (accept && mode == afts_pkg::MODE_LOAD && 32'(frame_slot) < 32'(MAX_FRAMES)) begin
      mem[AW'(frame_slot)] <= duration_ms;
    end
    rdata <= mem[rd_addr];
  end

  afts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (t),
    .divisor   (total),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Sequencer: sum the sequence, reduce the time on a nonzero sum, then scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      div_go  <= 1'b0;
      rd_pend <= 1'b0;
      k       <= '0;
      q_tag   <= 1'b0;
      len     <= '0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode == afts_pkg::MODE_LOAD) begin
              done        <= 1'b1;
              frame_index <= frame_slot;
              status      <= afts_pkg::ST_OK;
            end else if (!use_tag && count == 9'd0) begin
              done        <= 1'b1;
              frame_index <= '0;
              status      <= afts_pkg::ST_NO_FRAMES;
            end else if (use_tag && tag_bad) begin
              done        <= 1'b1;
              frame_index <= '0;
              status      <= afts_pkg::ST_BAD_TAG;
            end else begin
              q_tag   <= use_tag;
              len     <= use_tag ? tag_len : count;
              t       <= time_ms;
              total   <= '0;
              k       <= '0;
              rd_pend <= 1'b0;
              state   <= S_SUM;
            end
          end
        end
        S_SUM: begin
          rd_pend <= issue;
          if (issue) k <= k + 9'd1;
          if (rd_pend) total <= total + SW'(rdata);
          if (walk_end) begin
            k   <= '0;
            acc <= '0;
            if (total != '0) begin
              div_go <= 1'b1;
              state  <= S_DIV;
            end else begin
              frame_index <= last_entry;
              state       <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            t           <= TW'(div_rem);
            frame_index <= last_entry;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= issue;
          f_pend  <= cur_entry;
          if (issue) k <= k + 9'd1;
          if (rd_pend) acc <= acc_sum;
          if (rd_pend && TW'(acc_sum) > t) begin
            done        <= 1'b1;
            frame_index <= f_pend;
            status      <= afts_pkg::ST_OK;
            rd_pend     <= 1'b0;
            state       <= S_IDLE;
          end else if (walk_end) begin
            done   <= 1'b1;
            status <= afts_pkg::ST_OK;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
